### hw/rtl/serial_link_shifter_defines.svh
// Assertion macros for the serial link shifter.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SERIAL_LINK_SHIFTER_DEFINES_SVH
`define SERIAL_LINK_SHIFTER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serial link shifter check failed");
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serial link shifter check failed");
`else
`define SLS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/sls_pkg.sv
// Shared types and constants for the serial link shifter.
// Used by sls_core and serial_link_shifter; no dependencies.
package sls_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 4;

	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE_DATA = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE_CTRL = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_DATA  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_CTRL  = 3'd4;

	localparam int unsigned START_BIT    = 7;
	localparam int unsigned FAST_SEL_BIT = 1;
	localparam int unsigned INT_CLK_BIT  = 0;
	localparam int unsigned FAST_CLK_BIT = 2;
	localparam int unsigned SLOW_CLK_BIT = 7;

	localparam logic [CNT_W-1:0]  XFER_BITS = 4'd8;
	localparam logic [BYTE_W-1:0] CLK_STEP  = 8'd4;

	typedef struct packed {
		logic              valid;
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] write_value;
	} sls_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_value;
		logic              irq;
	} sls_rsp_t;

endpackage

### hw/rtl/sls_core.sv
// Register state and combinational step logic of the serial link shifter.
// Depends on sls_pkg.
module sls_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  sls_pkg::sls_req_t req,
	output sls_pkg::sls_rsp_t rsp
);
	import sls_pkg::*;

	logic              colour_mode_q;
	logic [BYTE_W-1:0] clock_count_q;
	logic [CNT_W-1:0]  bits_left_q;
	logic [BYTE_W-1:0] shift_reg_q;
	logic [BYTE_W-1:0] control_reg_q;
	logic              xfer_sig_q;
	logic              xfer_sig_prev_q;
	logic              clk_bit_prev_q;

	logic [BYTE_W-1:0] clock_count_d;
	logic [CNT_W-1:0]  bits_left_d;
	logic [CNT_W-1:0]  bits_start;
	logic [BYTE_W-1:0] shift_reg_d;
	logic [BYTE_W-1:0] control_reg_d;
	logic              xfer_sig_d;
	logic              xfer_sig_prev_d;
	logic              clk_bit_prev_d;
	logic              shift_now;
	logic              sel_bit;
	logic              level;

	always_comb begin
		clock_count_d   = clock_count_q;
		bits_left_d     = bits_left_q;
		shift_reg_d     = shift_reg_q;
		control_reg_d   = control_reg_q;
		xfer_sig_d      = xfer_sig_q;
		xfer_sig_prev_d = xfer_sig_prev_q;
		clk_bit_prev_d  = clk_bit_prev_q;
		rsp             = '0;
		bits_start      = bits_left_q;
		shift_now       = 1'b0;
		sel_bit         = 1'b0;
		level           = 1'b0;
		if (req.valid) begin
			unique case (req.op)
				OP_TICK: begin
					clock_count_d = clock_count_q + CLK_STEP;
					if (bits_left_q == '0 && control_reg_q[START_BIT]) begin
						bits_start = XFER_BITS;
					end
					bits_left_d = bits_start;
					shift_now = (bits_start != '0) && !xfer_sig_q && xfer_sig_prev_q;
					if (shift_now) begin
						shift_reg_d = {shift_reg_q[BYTE_W-2:0], 1'b1};
						bits_left_d = bits_start - 4'd1;
						if (bits_left_d == '0) begin
							control_reg_d[START_BIT] = 1'b0;
							rsp.irq = 1'b1;
						end
					end
					xfer_sig_prev_d = xfer_sig_q;
					sel_bit = (colour_mode_q && control_reg_q[FAST_SEL_BIT]) ?
						clock_count_d[FAST_CLK_BIT] : clock_count_d[SLOW_CLK_BIT];
					level = sel_bit && control_reg_q[INT_CLK_BIT];
					if (!level && clk_bit_prev_q) begin
						xfer_sig_d = !xfer_sig_q;
					end
					clk_bit_prev_d = level;
				end
				OP_WRITE_DATA: shift_reg_d = req.write_value;
				OP_WRITE_CTRL: control_reg_d = req.write_value;
				OP_READ_DATA:  rsp.read_value = shift_reg_q;
				OP_READ_CTRL:  rsp.read_value = control_reg_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_mode_q   <= 1'b0;
			clock_count_q   <= '0;
			bits_left_q     <= '0;
			shift_reg_q     <= '0;
			control_reg_q   <= '0;
			xfer_sig_q      <= 1'b0;
			xfer_sig_prev_q <= 1'b0;
			clk_bit_prev_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				colour_mode_q <= cfg_wr_data;
			end
			clock_count_q   <= clock_count_d;
			bits_left_q     <= bits_left_d;
			shift_reg_q     <= shift_reg_d;
			control_reg_q   <= control_reg_d;
			xfer_sig_q      <= xfer_sig_d;
			xfer_sig_prev_q <= xfer_sig_prev_d;
			clk_bit_prev_q  <= clk_bit_prev_d;
		end
	end

endmodule

### hw/rtl/serial_link_shifter.sv
// The serial link shifter accepts one request per clock while the result path is not stalled
// and returns one result per request: a request is captured in an input register, then the
// core updates the port state and loads the result register. The colour_mode register is
// written through cfg_wr_en/cfg_wr_data.
// Depends on sls_pkg, sls_core and serial_link_shifter_defines.svh.
`include "serial_link_shifter_defines.svh"

module serial_link_shifter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [sls_pkg::OP_W-1:0]   op,
	input  logic [sls_pkg::BYTE_W-1:0] write_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sls_pkg::BYTE_W-1:0] read_value,
	output logic                      irq
);
	import sls_pkg::*;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [BYTE_W-1:0] write_value_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] read_value_q;
	logic              irq_q;
	logic              advance;
	sls_req_t          req;
	sls_rsp_t          rsp;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign req.valid       = valid_s1 && advance;
	assign req.op          = op_s1;
	assign req.write_value = write_value_s1;

	sls_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1          <= op;
			write_value_s1 <= write_value;
		end
		if (req.valid) begin
			read_value_q <= rsp.read_value;
			irq_q        <= rsp.irq;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign irq        = irq_q;

	`SLS_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && !out_valid_q, out_valid_q)
	`SLS_ASSERT_NOW(a_irq_no_read, clk, arst_n, out_valid_q && irq_q, read_value_q == '0)
	`SLS_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && !out_ready, $stable(irq_q) && $stable(read_value_q))

endmodule

### tb/tb_serial_link_shifter.sv
// Self-checking testbench for serial_link_shifter: directed register accesses, then long random
// transfer sequences under random input gaps and output stalls, checked against a predictor.
// Depends on sls_pkg and the serial_link_shifter RTL only.
import sls_pkg::*;

class link_port_model;
	logic              colour_mode;
	logic [BYTE_W-1:0] clock_count;
	logic [CNT_W-1:0]  bits_left;
	logic [BYTE_W-1:0] data_reg;
	logic [BYTE_W-1:0] ctrl_reg;
	logic              xfer;
	logic              xfer_prev;
	logic              clk_bit_prev;
	sls_rsp_t          expected_replies[$];
	int unsigned       mismatches;

	function new();
		colour_mode  = 1'b0;
		clock_count  = '0;
		bits_left    = '0;
		data_reg     = '0;
		ctrl_reg     = '0;
		xfer         = 1'b0;
		xfer_prev    = 1'b0;
		clk_bit_prev = 1'b0;
		mismatches   = 0;
	endfunction

	function void set_colour_mode(input logic mode);
		colour_mode = mode;
	endfunction

	function int unsigned pending();
		return expected_replies.size();
	endfunction

	function logic machine_tick();
		logic fired;
		logic level;
		fired = 1'b0;
		clock_count = clock_count + CLK_STEP;
		if (bits_left == 0 && ctrl_reg[START_BIT]) begin
			bits_left = XFER_BITS;
		end
		// The link is disconnected, so every shifted-in bit is a one.
		if (bits_left != 0 && !xfer && xfer_prev) begin
			data_reg  = {data_reg[BYTE_W-2:0], 1'b1};
			bits_left = bits_left - 1'b1;
			if (bits_left == 0) begin
				ctrl_reg[START_BIT] = 1'b0;
				fired = 1'b1;
			end
		end
		xfer_prev = xfer;
		if (colour_mode && ctrl_reg[FAST_SEL_BIT]) begin
			level = clock_count[FAST_CLK_BIT];
		end else begin
			level = clock_count[SLOW_CLK_BIT];
		end
		level = level && ctrl_reg[INT_CLK_BIT];
		if (!level && clk_bit_prev) begin
			xfer = !xfer;
		end
		clk_bit_prev = level;
		return fired;
	endfunction

	function void take_request(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] value);
		sls_rsp_t reply;
		reply = '0;
		case (code)
			OP_TICK:       reply.irq = machine_tick();
			OP_WRITE_DATA: data_reg = value;
			OP_WRITE_CTRL: ctrl_reg = value;
			OP_READ_DATA:  reply.read_value = data_reg;
			OP_READ_CTRL:  reply.read_value = ctrl_reg;
			default:       reply = '0;
		endcase
		expected_replies.push_back(reply);
	endfunction

	function void report(input string what, input sls_rsp_t want, input sls_rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected read_value %02h irq %0d, got read_value %02h irq %0d",
				what, want.read_value, want.irq, got.read_value, got.irq);
		end
	endfunction

	function void check_reply(input logic [BYTE_W-1:0] value, input logic irq_bit);
		sls_rsp_t got;
		sls_rsp_t want;
		got.read_value = value;
		got.irq = irq_bit;
		if (expected_replies.size() == 0) begin
			report("Result with no request outstanding", '0, got);
		end else begin
			want = expected_replies.pop_front();
			if (got.read_value !== want.read_value || got.irq !== want.irq) begin
				report("Result mismatch", want, got);
			end
		end
	endfunction
endclass

module tb_serial_link_shifter;
	typedef logic [OP_W-1:0] op_code_t;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam op_code_t    OP_SPARE_LO = 3'd5;
	localparam op_code_t    OP_SPARE_HI = 3'd7;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic              cfg_wr_data = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	op_code_t          op          = OP_TICK;
	logic [BYTE_W-1:0] write_value = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [BYTE_W-1:0] read_value;
	logic              irq;

	link_port_model port_model;
	int unsigned    requests_sent = 0;
	int unsigned    replies_seen  = 0;
	int unsigned    irq_count     = 0;
	int unsigned    stall_cycles  = 0;
	int unsigned    burst_left    = 0;
	bit             no_gaps       = 1'b0;
	bit             hold_req      = 1'b0;
	int unsigned    hold_left     = 0;
	int unsigned    rx_cycle      = 0;
	int unsigned    rx_mode       = 0;

	serial_link_shifter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.irq        (irq)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= $urandom_range(0, 1);
				2:       out_ready <= (rx_cycle % 4 == 0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				port_model.check_reply(read_value, irq);
				replies_seen++;
				if (irq) begin
					irq_count++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	task automatic send_request(input op_code_t code, input logic [BYTE_W-1:0] value);
		in_valid <= 1'b1;
		op <= code;
		write_value <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		port_model.take_request(code, value);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic issue(input op_code_t code, input logic [BYTE_W-1:0] value);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!no_gaps) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		send_request(code, value);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(negedge clk); while (port_model.pending() != 0);
	endtask

	task automatic set_colour_mode(input logic mode);
		drain_replies();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		port_model.set_colour_mode(mode);
	endtask

	task automatic run_transfer_sequence(input int unsigned max_ticks);
		logic [BYTE_W-1:0] ctrl;
		int unsigned       n;
		ctrl = BYTE_W'($urandom);
		ctrl[START_BIT] = ($urandom_range(0, 9) != 0);
		ctrl[INT_CLK_BIT] = ($urandom_range(0, 9) != 0);
		ctrl[FAST_SEL_BIT] = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 4) != 0) begin
			issue(OP_WRITE_DATA, BYTE_W'($urandom));
		end
		issue(OP_WRITE_CTRL, ctrl);
		n = $urandom_range(8, max_ticks);
		repeat (n) begin
			case ($urandom_range(0, 39))
				0, 1:    issue(OP_READ_DATA, BYTE_W'($urandom));
				2, 3:    issue(OP_READ_CTRL, BYTE_W'($urandom));
				4:       issue(OP_WRITE_DATA, BYTE_W'($urandom));
				5:       issue(OP_WRITE_CTRL, BYTE_W'($urandom));
				default: issue(OP_TICK, BYTE_W'($urandom));
			endcase
		end
		issue(OP_READ_DATA, BYTE_W'($urandom));
		issue(OP_READ_CTRL, BYTE_W'($urandom));
	endtask

	task automatic run_phase(input int unsigned quota, input int unsigned max_ticks);
		int unsigned stop_at;
		stop_at = requests_sent + quota;
		while (requests_sent < stop_at) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) begin
				run_transfer_sequence(max_ticks);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					issue(op_code_t'($urandom_range(0, 7)), BYTE_W'($urandom));
				end
			end
		end
	endtask

	initial begin
		port_model = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_colour_mode(1'b0);

		issue(OP_READ_DATA, 8'hFF);
		issue(OP_READ_CTRL, 8'h00);
		issue(OP_WRITE_DATA, 8'hFF);
		issue(OP_READ_DATA, 8'h00);
		issue(OP_WRITE_DATA, 8'h00);
		issue(OP_READ_DATA, 8'hFF);
		issue(OP_WRITE_CTRL, 8'hFF);
		issue(OP_READ_CTRL, 8'h00);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) begin
			issue(op_code_t'(c), 8'hFF);
		end
		repeat (4) issue(OP_TICK, 8'hFF);
		issue(OP_WRITE_DATA, 8'hA5);
		issue(OP_WRITE_CTRL, 8'h00);
		issue(OP_TICK, 8'h00);
		issue(OP_READ_CTRL, 8'h00);
		issue(OP_READ_DATA, 8'h00);
		issue(OP_WRITE_CTRL, 8'h81);
		repeat (2) issue(OP_TICK, 8'h00);

		set_colour_mode(1'b1);
		run_phase(450, 60);

		set_colour_mode(1'b0);
		run_phase(450, 200);

		set_colour_mode(1'b1);
		hold_req = 1'b1;
		repeat (40) begin
			send_request(($urandom_range(0, 3) == 0) ? OP_READ_DATA : OP_TICK, BYTE_W'($urandom));
		end
		drain_replies();
		run_phase(350, 60);

		drain_replies();
		repeat (20) @(negedge clk);
		$display("Covered %0d requests and %0d results, %0d of them transfer interrupts,",
			requests_sent, replies_seen, irq_count);
		$display("in both clock modes, with a long output stall and %0d mismatches.",
			port_model.mismatches);
		if (port_model.mismatches == 0 && port_model.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
